FILE: hw/rtl/bpt_pkg.sv
// ----------------------------------------------------------------------------
// Branch predictor table package
// Shared types, constants and the 2-bit state transition function.
// ----------------------------------------------------------------------------
package bpt_pkg;

  // Table geometry.
  localparam int unsigned PREDICTOR_ENTRIES = 1024;
  localparam int unsigned IDX_W             = $clog2(PREDICTOR_ENTRIES);
  localparam int unsigned ENTRY_IDX_W       = 10;

  // Register field widths.
  localparam int unsigned SHIFT_W = 3;
  localparam int unsigned BITS_W  = 4;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_SHIFT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS    = 4'd1;

  // Register reset values.
  localparam logic [SHIFT_W-1:0] ADDRESS_SHIFT_RST = 3'd1;
  localparam logic [BITS_W-1:0]  INDEX_BITS_RST    = 4'd10;

  // Predictor states.
  localparam logic [1:0] ST_STRONG_NT = 2'b00;
  localparam logic [1:0] ST_INIT_VAL  = 2'b01;
  localparam logic [1:0] ST_WEAK_T    = 2'b10;
  localparam logic [1:0] ST_STRONG_T  = 2'b11;

  // Item kinds.
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] branch_address;
    logic        taken;
  } bpt_in_t;

  typedef struct packed {
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [1:0]             prior_state;
    logic                   predicted_taken;
    logic                   prediction_correct;
  } bpt_out_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOKUP,
    S_SWEEP,
    S_CLEAR_DONE
  } bpt_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic accept;        // capture update item and issue the table read
    logic sweep_write;   // write the initial state at the sweep address
    logic finish_update; // write back the next state and load the result
    logic finish_clear;  // load the all-zero result of a clear item
  } bpt_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic sweep_last; // sweep address is at the last entry
    logic res_free;   // result register can take a new result
  } bpt_status_t;

  // Next predictor state for an old state and the actual outcome.
  function automatic logic [1:0] next_state(input logic [1:0] old, input logic tk);
    logic [1:0] ns;
    unique case (old)
      ST_STRONG_NT: ns = tk ? ST_INIT_VAL : ST_STRONG_NT;
      ST_INIT_VAL:  ns = tk ? ST_STRONG_T : ST_STRONG_NT;
      ST_WEAK_T:    ns = tk ? ST_STRONG_T : ST_STRONG_NT;
      default:      ns = tk ? ST_STRONG_T : ST_WEAK_T;
    endcase
    return ns;
  endfunction

endpackage

FILE: hw/rtl/bpt_ctrl.sv
// ----------------------------------------------------------------------------
// Branch predictor table controller
// Sequences table sweeps, read-modify-write updates and result loading.
// ----------------------------------------------------------------------------
module bpt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 upd_valid,
  input  logic                 upd_kind,
  output logic                 upd_ready,
  input  bpt_pkg::bpt_status_t status,
  output bpt_pkg::bpt_cmd_t    cmd
);

  bpt_pkg::bpt_state_t state;
  bpt_pkg::bpt_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpt_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      bpt_pkg::S_INIT: begin
        if (status.sweep_last) state_next = bpt_pkg::S_IDLE;
      end
      bpt_pkg::S_IDLE: begin
        if (upd_valid) begin
          state_next = (upd_kind == bpt_pkg::KIND_CLEAR) ? bpt_pkg::S_SWEEP
                                                         : bpt_pkg::S_LOOKUP;
        end
      end
      bpt_pkg::S_LOOKUP: begin
        if (status.res_free) state_next = bpt_pkg::S_IDLE;
      end
      bpt_pkg::S_SWEEP: begin
        if (status.sweep_last) state_next = bpt_pkg::S_CLEAR_DONE;
      end
      bpt_pkg::S_CLEAR_DONE: begin
        if (status.res_free) state_next = bpt_pkg::S_IDLE;
      end
      default: state_next = bpt_pkg::S_INIT;
    endcase
  end

  // Output logic.
  always_comb begin
    upd_ready = 1'b0;
    cmd       = '0;
    unique case (state)
      bpt_pkg::S_INIT: begin
        cmd.sweep_write = 1'b1;
      end
      bpt_pkg::S_IDLE: begin
        upd_ready  = 1'b1;
        cmd.accept = upd_valid && (upd_kind == bpt_pkg::KIND_UPDATE);
      end
      bpt_pkg::S_LOOKUP: begin
        cmd.finish_update = status.res_free;
      end
      bpt_pkg::S_SWEEP: begin
        cmd.sweep_write = 1'b1;
      end
      bpt_pkg::S_CLEAR_DONE: begin
        cmd.finish_clear = status.res_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/bpt_dp.sv
// ----------------------------------------------------------------------------
// Branch predictor table datapath
// Configuration registers, predictor memory, sweep counter and result register.
// ----------------------------------------------------------------------------
module bpt_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  bpt_pkg::bpt_cmd_t                   cmd,
  output bpt_pkg::bpt_status_t                status,
  input  bpt_pkg::bpt_in_t                    upd_data,
  input  logic                                cfg_valid,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpt_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                res_valid,
  input  logic                                res_ready,
  output bpt_pkg::bpt_out_t                   res_data
);

  logic [bpt_pkg::SHIFT_W-1:0] address_shift;
  logic [bpt_pkg::BITS_W-1:0]  index_bits;

  logic [1:0]              mem [bpt_pkg::PREDICTOR_ENTRIES];
  logic [1:0]              rd_data;
  logic [bpt_pkg::IDX_W-1:0] sweep_cnt;
  logic [bpt_pkg::IDX_W-1:0] item_idx;
  logic                      item_taken;

  logic [63:0]               shifted;
  logic [bpt_pkg::IDX_W-1:0] idx_mask;
  logic [bpt_pkg::IDX_W-1:0] lookup_idx;
  logic                      wr_en;
  logic [bpt_pkg::IDX_W-1:0] wr_addr;
  logic [1:0]                wr_val;

  // Configuration registers; writes to other indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      address_shift <= bpt_pkg::ADDRESS_SHIFT_RST;
      index_bits    <= bpt_pkg::INDEX_BITS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == bpt_pkg::REG_ADDRESS_SHIFT) begin
        address_shift <= cfg_data[bpt_pkg::SHIFT_W-1:0];
      end else if (cfg_index == bpt_pkg::REG_INDEX_BITS) begin
        index_bits <= cfg_data[bpt_pkg::BITS_W-1:0];
      end
    end
  end

  // Table index: shifted address masked to the configured width.
  // A mask count at or above the table width keeps every index bit.
  assign shifted    = upd_data.branch_address >> address_shift;
  assign idx_mask   = ~({bpt_pkg::IDX_W{1'b1}} << index_bits);
  assign lookup_idx = shifted[bpt_pkg::IDX_W-1:0] & idx_mask;

  // Capture the update item when it is accepted.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_idx   <= lookup_idx;
      item_taken <= upd_data.taken;
    end
  end

  // Sweep address counter, wraps to zero after the last entry.
  assign status.sweep_last = (sweep_cnt == bpt_pkg::IDX_W'(bpt_pkg::PREDICTOR_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_write) begin
      sweep_cnt <= status.sweep_last ? '0 : sweep_cnt + 1'b1;
    end
  end

  // Single write port shared by the sweep and the update write-back.
  assign wr_en   = cmd.sweep_write || cmd.finish_update;
  assign wr_addr = cmd.sweep_write ? sweep_cnt : item_idx;
  assign wr_val  = cmd.sweep_write ? bpt_pkg::ST_INIT_VAL
                                   : bpt_pkg::next_state(rd_data, item_taken);

  // Predictor memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_val;
    end
    if (cmd.accept) begin
      rd_data <= mem[lookup_idx];
    end
  end

  // Result register.
  assign status.res_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish_update || cmd.finish_clear) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_update) begin
      res_data.entry_index        <= bpt_pkg::ENTRY_IDX_W'(item_idx);
      res_data.prior_state        <= rd_data;
      res_data.predicted_taken    <= rd_data[1];
      res_data.prediction_correct <= (rd_data[1] == item_taken);
    end else if (cmd.finish_clear) begin
      res_data <= '0;
    end
  end

  // The sweep and the update write-back never share the write port.
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.sweep_write && cmd.finish_update))
    else $error("sweep and update write collide");

  // A finished result always shows up on the result channel.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.finish_update || cmd.finish_clear) |=> res_valid)
    else $error("finished result not presented");

  // A result of a clear transaction carries all-zero fields.
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish_clear |=> (res_data == '0))
    else $error("clear result not zero");

  // The last sweep write returns the counter to the first entry.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.sweep_write && status.sweep_last) |=> (sweep_cnt == '0))
    else $error("sweep counter did not wrap");

endmodule

FILE: hw/rtl/branch_predictor_table.sv
// ----------------------------------------------------------------------------
// Branch predictor table
// Direct-mapped table of 2-bit branch predictor states with update and clear.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                              Role
//   upd      upd_valid upd_ready upd_data         update or clear transaction in
//   res      res_valid res_ready res_data         one result per transaction out
//   cfg      cfg_valid cfg_ready cfg_index cfg_data  register write
//
// An update issues the registered memory read when it is accepted, then writes
// back the next state through the single write port before the next is taken.
// A clear sweeps the table one entry a cycle.
// After reset the same sweep runs over every entry before upd_ready.
// A result waits in its output register; the next transaction is taken meanwhile
// and stalls only at its own result load while res_ready is low.
// Register writes are always taken.
// ----------------------------------------------------------------------------
module branch_predictor_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           upd_valid,
  output logic                           upd_ready,
  input  bpt_pkg::bpt_in_t               upd_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output bpt_pkg::bpt_out_t              res_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpt_pkg::CFG_DATA_W-1:0] cfg_data
);

  bpt_pkg::bpt_cmd_t    cmd;
  bpt_pkg::bpt_status_t status;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready = 1'b1;

  // Controller.
  bpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .upd_valid (upd_valid),
    .upd_kind  (upd_data.kind),
    .upd_ready (upd_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  bpt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .upd_data  (upd_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule
